// ===== rtl/hsv2rgb_pkg.sv =====
// Shared types and constants for the HSV to RGB pixel converter.
// No dependencies; every rtl module imports this package.
`default_nettype none

package hsv2rgb_pkg;

  // Input limits
  localparam logic [8:0] HueLimit = 9'd360;
  localparam logic [6:0] PctLimit = 7'd100;

  // One in Q16
  localparam logic [16:0] OneQ16 = 17'h10000;

  // Percent to Q16: floor(p * 2^14 / 25) as multiply by ceil(2^26 / 25)
  localparam logic [21:0] PctRecip = 22'd2684355;
  localparam int unsigned PctShift = 26;

  // Sector distance to Q16: floor(d * 2^14 / 15) as multiply by ceil(2^25 / 15)
  localparam logic [21:0] DistRecip = 22'd2236963;
  localparam int unsigned DistShift = 25;

  // Hue sector boundaries in degrees
  localparam logic [8:0] Hue60  = 9'd60;
  localparam logic [8:0] Hue120 = 9'd120;
  localparam logic [8:0] Hue180 = 9'd180;
  localparam logic [8:0] Hue240 = 9'd240;
  localparam logic [8:0] Hue300 = 9'd300;
  localparam logic [6:0] SectorDeg = 7'd60;

  typedef enum logic [2:0] {
    SectorRedYel = 3'd0,
    SectorYelGrn = 3'd1,
    SectorGrnCyn = 3'd2,
    SectorCynBlu = 3'd3,
    SectorBluMag = 3'd4,
    SectorMagRed = 3'd5
  } sector_e;

  // Input beat
  typedef struct packed {
    logic [8:0] hue_deg;
    logic [6:0] saturation_pct;
    logic [6:0] value_pct;
  } hsv_beat_t;

  // Output beat
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_of_range;
  } rgb_beat_t;

  // After the scaling stage
  typedef struct packed {
    logic [16:0] sat_q;
    logic [16:0] val_q;
    logic [16:0] dist_q;
    sector_e     sector;
    logic        out_of_range;
  } front_t;

  // After the chroma stages
  typedef struct packed {
    logic [16:0] chroma_q;
    logic [16:0] second_q;
    logic [16:0] offset_q;
    sector_e     sector;
    logic        out_of_range;
  } chroma_t;

endpackage

`default_nettype wire

// ===== rtl/hsv2rgb_front.sv =====
// Front stage: range check, hue sector, and Q16 scaling of s, v and sector distance.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  hsv2rgb_pkg::hsv_beat_t data_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output hsv2rgb_pkg::front_t    data_o
);
  import hsv2rgb_pkg::*;

  logic        valid_q;
  front_t      data_q, data_d;
  sector_e     sector;
  logic [8:0]  hue_wrap;
  logic [6:0]  hue_mod;
  logic [5:0]  hue_dist;
  logic [42:0] sat_prod;
  logic [42:0] val_prod;
  logic [41:0] dist_prod;

  // Pick the 60-degree sector; hue of 360 lands in the last one
  always_comb begin
    if (data_i.hue_deg < Hue60) begin
      sector = SectorRedYel;
    end else if (data_i.hue_deg < Hue120) begin
      sector = SectorYelGrn;
    end else if (data_i.hue_deg < Hue180) begin
      sector = SectorGrnCyn;
    end else if (data_i.hue_deg < Hue240) begin
      sector = SectorCynBlu;
    end else if (data_i.hue_deg < Hue300) begin
      sector = SectorBluMag;
    end else begin
      sector = SectorMagRed;
    end
  end

  // Fold hue into one 120-degree period and measure distance from its middle
  always_comb begin
    if (sector == SectorBluMag || sector == SectorMagRed) begin
      hue_wrap = data_i.hue_deg - Hue240;
    end else if (sector == SectorGrnCyn || sector == SectorCynBlu) begin
      hue_wrap = data_i.hue_deg - Hue120;
    end else begin
      hue_wrap = data_i.hue_deg;
    end
    hue_mod = hue_wrap[6:0];
    if (hue_mod >= SectorDeg) begin
      hue_dist = 6'(hue_mod - SectorDeg);
    end else begin
      hue_dist = 6'(SectorDeg - hue_mod);
    end
  end

  // Scale to Q16 by reciprocal multiply
  assign sat_prod  = 43'({data_i.saturation_pct, 14'd0}) * 43'(PctRecip);
  assign val_prod  = 43'({data_i.value_pct, 14'd0}) * 43'(PctRecip);
  assign dist_prod = 42'({hue_dist, 14'd0}) * 42'(DistRecip);

  always_comb begin
    data_d.sat_q        = sat_prod[PctShift +: 17];
    data_d.val_q        = val_prod[PctShift +: 17];
    data_d.dist_q       = dist_prod[DistShift +: 17];
    data_d.sector       = sector;
    data_d.out_of_range = (data_i.hue_deg > HueLimit) ||
                          (data_i.saturation_pct > PctLimit) ||
                          (data_i.value_pct > PctLimit);
  end

  // Advance when this stage is empty or downstream takes its beat
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  a_scaled_in_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.out_of_range |->
      data_q.sat_q <= OneQ16 && data_q.val_q <= OneQ16 && data_q.dist_q <= OneQ16)
    else $error("scaled operand above one for an in-range beat");

endmodule

`default_nettype wire

// ===== rtl/hsv2rgb_chroma.sv =====
// Two multiplier stages: chroma C = s*v, then X = C*(1-t) and offset m = v-C.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_chroma (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  hsv2rgb_pkg::front_t  data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output hsv2rgb_pkg::chroma_t data_o
);
  import hsv2rgb_pkg::*;

  // Stage A holds C alongside v, t and sector
  logic        a_valid_q;
  logic        a_ready;
  front_t      a_data_q;
  logic [16:0] a_chroma_q;
  logic [33:0] sv_prod;

  // Stage B holds C, X and m
  logic        b_valid_q;
  chroma_t     b_data_q, b_data_d;
  logic [16:0] one_minus_t;
  logic [33:0] x_prod;

  // Stage A: chroma product
  assign sv_prod = 34'(data_i.sat_q) * 34'(data_i.val_q);
  assign ready_o = !a_valid_q || a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (ready_o) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      a_data_q   <= data_i;
      a_chroma_q <= sv_prod[32:16];
    end
  end

  // Stage B: second component and offset
  assign one_minus_t = OneQ16 - a_data_q.dist_q;
  assign x_prod      = 34'(a_chroma_q) * 34'(one_minus_t);

  always_comb begin
    b_data_d.chroma_q     = a_chroma_q;
    b_data_d.second_q     = x_prod[32:16];
    b_data_d.offset_q     = a_data_q.val_q - a_chroma_q;
    b_data_d.sector       = a_data_q.sector;
    b_data_d.out_of_range = a_data_q.out_of_range;
  end

  assign a_ready = !b_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && a_valid_q) begin
      b_data_q <= b_data_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_data_q;

  a_second_le_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !b_data_q.out_of_range |-> b_data_q.second_q <= b_data_q.chroma_q)
    else $error("X exceeds chroma for an in-range beat");

  a_chroma_le_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_data_q.out_of_range |-> a_chroma_q <= a_data_q.val_q)
    else $error("chroma exceeds value for an in-range beat");

endmodule

`default_nettype wire

// ===== rtl/hsv2rgb_mix.sv =====
// Output stage: place C, X and 0 by sector, add m, scale by 255, register result.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_mix (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  hsv2rgb_pkg::chroma_t   data_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output hsv2rgb_pkg::rgb_beat_t data_o
);
  import hsv2rgb_pkg::*;

  logic        valid_q;
  rgb_beat_t   data_q, data_d;
  logic [16:0] comp_r, comp_g, comp_b;

  // (comp + m) * 255 >> 16, saturated at 255
  function automatic logic [7:0] to_channel(logic [16:0] comp, logic [16:0] offs);
    logic [17:0] sum;
    logic [25:0] scaled;
    sum    = 18'(comp) + 18'(offs);
    scaled = {sum, 8'd0} - 26'(sum);
    if (scaled[25:24] != 2'b00) begin
      to_channel = 8'hFF;
    end else begin
      to_channel = scaled[23:16];
    end
  endfunction

  // Route components by sector
  always_comb begin
    unique case (data_i.sector)
      SectorRedYel: begin
        comp_r = data_i.chroma_q; comp_g = data_i.second_q; comp_b = '0;
      end
      SectorYelGrn: begin
        comp_r = data_i.second_q; comp_g = data_i.chroma_q; comp_b = '0;
      end
      SectorGrnCyn: begin
        comp_r = '0; comp_g = data_i.chroma_q; comp_b = data_i.second_q;
      end
      SectorCynBlu: begin
        comp_r = '0; comp_g = data_i.second_q; comp_b = data_i.chroma_q;
      end
      SectorBluMag: begin
        comp_r = data_i.second_q; comp_g = '0; comp_b = data_i.chroma_q;
      end
      default: begin
        comp_r = data_i.chroma_q; comp_g = '0; comp_b = data_i.second_q;
      end
    endcase
  end

  // Drop color on an out-of-range beat
  always_comb begin
    data_d.out_of_range = data_i.out_of_range;
    if (data_i.out_of_range) begin
      data_d.red   = '0;
      data_d.green = '0;
      data_d.blue  = '0;
    end else begin
      data_d.red   = to_channel(comp_r, data_i.offset_q);
      data_d.green = to_channel(comp_g, data_i.offset_q);
      data_d.blue  = to_channel(comp_b, data_i.offset_q);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  a_oor_is_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && data_q.out_of_range |->
      data_q.red == 8'd0 && data_q.green == 8'd0 && data_q.blue == 8'd0)
    else $error("out-of-range beat carries color");

endmodule

`default_nettype wire

// ===== rtl/hsv_to_rgb_convert_top.sv =====
// Top level of the HSV to RGB pixel converter: front, chroma and mix stages.
// Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_chroma, hsv2rgb_mix.
//
//   Channel | Handshake                 | Beat
//   --------+---------------------------+---------------------------------------
//   input   | in_valid_i / in_ready_o   | hue_deg, saturation_pct, value_pct
//   output  | out_valid_o / out_ready_i | red, green, blue, out_of_range
//
// Accepts one beat per clock while the output is not stalled; each result passes
// through the scale, chroma multiply, X multiply and output registers in turn.
// Reset clears only the stage valid bits; data registers are not reset.
// Each stage advances when empty or when the next stage takes its beat, so a
// stall at the output backs up stage by stage without losing or repeating beats.
`default_nettype none

module hsv_to_rgb_convert_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  hsv2rgb_pkg::hsv_beat_t in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output hsv2rgb_pkg::rgb_beat_t out_data_o
);
  import hsv2rgb_pkg::*;

  logic    front_valid, front_ready;
  front_t  front_data;
  logic    chroma_valid, chroma_ready;
  chroma_t chroma_data;

  hsv2rgb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (front_valid),
    .ready_i (front_ready),
    .data_o  (front_data)
  );

  hsv2rgb_chroma u_chroma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .data_i  (front_data),
    .valid_o (chroma_valid),
    .ready_i (chroma_ready),
    .data_o  (chroma_data)
  );

  hsv2rgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chroma_valid),
    .ready_o (chroma_ready),
    .data_i  (chroma_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // Input backs up only when every stage is full and the output is stalled
  a_backpressure_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && front_valid && chroma_valid)
    else $error("input stalled without a full pipeline");

  a_result_from_pipeline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(chroma_valid))
    else $error("result appeared without a beat in the chroma stage");

endmodule

`default_nettype wire
